// ----- rtl/core/sll_pkg.sv -----
// small language lexer: shared types, character codes and classifier functions
// no dependencies; used by the interfaces' users, the lexing core and the top level
package sll_pkg;

   localparam int MAX_LEXEME  = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [5:0] {
      MODE_IDLE  = 6'b000001,
      MODE_IDENT = 6'b000010,
      MODE_NUM   = 6'b000100,
      MODE_BANG  = 6'b001000,
      MODE_EQ    = 6'b010000,
      MODE_ERR   = 6'b100000
   } mode_type;

   typedef enum logic [3:0] {
      KIND_TYPE   = 4'd0,
      KIND_IDENT  = 4'd1,
      KIND_NUMBER = 4'd2,
      KIND_WHILE  = 4'd3,
      KIND_RETURN = 4'd4,
      KIND_LBRACE = 4'd5,
      KIND_RBRACE = 4'd6,
      KIND_LPAREN = 4'd7,
      KIND_RPAREN = 4'd8,
      KIND_SEMI   = 4'd9,
      KIND_COMMA  = 4'd10,
      KIND_BINOP  = 4'd11,
      KIND_ASSIGN = 4'd12,
      KIND_ERROR  = 4'd13
   } kind_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam logic [47:0] KW_INT    = 48'h0000_0069_6E74;
   localparam logic [47:0] KW_VOID   = 48'h0000_766F_6964;
   localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6C65;
   localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [8:0]  length;
   } token_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] start;
      logic [8:0]  length;
      logic [47:0] prefix;
   } lex_state_type;

   typedef struct packed {
      token_type  tok0;
      token_type  tok1;
      logic [1:0] count;
   } lex_result_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } rsp_item_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_white(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_struct(logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
             (c == CH_RPAREN) || (c == CH_EQ) || (c == CH_STAR) || (c == CH_PLUS) ||
             (c == CH_BANG) || (c == CH_SEMI) || (c == CH_COMMA);
   endfunction

   function automatic kind_type word_kind(logic [8:0] len, logic [47:0] pref);
      kind_type k;
      k = KIND_IDENT;
      priority if (len == 9'd3 && pref == KW_INT) begin
         k = KIND_TYPE;
      end else if (len == 9'd4 && pref == KW_VOID) begin
         k = KIND_TYPE;
      end else if (len == 9'd5 && pref == KW_WHILE) begin
         k = KIND_WHILE;
      end else if (len == 9'd6 && pref == KW_RETURN) begin
         k = KIND_RETURN;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

endpackage

// ----- rtl/core/sll_if.sv -----
// small language lexer: valid/ready channel interfaces for characters and tokens
// no dependencies
interface sll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_stream;

   modport source (output valid, output ch, output end_of_stream, input ready);
   modport sink   (input valid, input ch, input end_of_stream, output ready);
endinterface

interface sll_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] start_offset;
   logic [8:0]  lexeme_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output lexeme_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input start_offset,
                   input lexeme_length, input last_of_run, output ready);
endinterface

// ----- rtl/core/sll_lex.sv -----
// small language lexer: next-state and token logic for one character
// depends on sll_pkg
module sll_lex (
   input  logic [7:0]             ch,
   input  logic                   eos,
   input  logic [31:0]            pos,
   input  sll_pkg::lex_state_type cur,
   output sll_pkg::lex_state_type nxt,
   output sll_pkg::lex_result_type res
);
   import sll_pkg::*;

   token_type  tok_a, tok_b, tok_c;
   logic       vld_a, vld_b, vld_c;
   logic       done;
   logic       cont;
   logic [1:0] total;

   always_comb begin
      nxt   = cur;
      tok_a = '{kind: KIND_ERROR, start: pos, length: 9'd1};
      tok_b = '{kind: KIND_ERROR, start: pos, length: 9'd1};
      tok_c = '{kind: KIND_ASSIGN, start: cur.start, length: 9'd1};
      vld_a = 1'b0;
      vld_b = 1'b0;
      vld_c = 1'b0;
      done  = 1'b0;
      cont  = 1'b0;

      // continuation of whatever the previous character left pending
      unique case (cur.mode)
         MODE_ERR: begin
            done = 1'b1;
         end
         MODE_IDENT, MODE_NUM: begin
            cont = (cur.mode == MODE_IDENT) ? (!is_white(ch) && !is_struct(ch))
                                            : is_digit(ch);
            if (cont) begin
               done = 1'b1;
               if (int'(cur.length) >= MAX_LEXEME) begin
                  vld_a      = 1'b1;
                  nxt.mode   = MODE_ERR;
                  nxt.length = '0;
                  nxt.prefix = '0;
               end else begin
                  nxt.length = cur.length + 9'd1;
                  nxt.prefix = {cur.prefix[39:0], ch};
               end
            end else begin
               vld_a = 1'b1;
               tok_a = '{kind: (cur.mode == MODE_IDENT) ? word_kind(cur.length, cur.prefix)
                                                        : KIND_NUMBER,
                         start: cur.start, length: cur.length};
               nxt.mode = MODE_IDLE;
            end
         end
         MODE_BANG, MODE_EQ: begin
            if (ch == CH_EQ) begin
               vld_a = 1'b1;
               tok_a = '{kind: KIND_BINOP, start: cur.start, length: 9'd2};
               done  = 1'b1;
            end else if (cur.mode == MODE_EQ) begin
               vld_a = 1'b1;
               tok_a = '{kind: KIND_ASSIGN, start: cur.start, length: 9'd1};
            end
            nxt.mode = MODE_IDLE;
         end
         default: begin
            nxt.mode = MODE_IDLE;
         end
      endcase

      // character lexed from idle
      if (!done) begin
         if (is_letter(ch) || is_digit(ch)) begin
            nxt.mode   = is_letter(ch) ? MODE_IDENT : MODE_NUM;
            nxt.start  = pos;
            nxt.length = 9'd1;
            nxt.prefix = {40'd0, ch};
         end else if (is_white(ch)) begin
            nxt.mode = MODE_IDLE;
         end else if (ch == CH_BANG || ch == CH_EQ) begin
            nxt.mode  = (ch == CH_BANG) ? MODE_BANG : MODE_EQ;
            nxt.start = pos;
         end else begin
            vld_b = 1'b1;
            priority case (ch)
               CH_LBRACE: tok_b.kind = KIND_LBRACE;
               CH_RBRACE: tok_b.kind = KIND_RBRACE;
               CH_LPAREN: tok_b.kind = KIND_LPAREN;
               CH_RPAREN: tok_b.kind = KIND_RPAREN;
               CH_SEMI:   tok_b.kind = KIND_SEMI;
               CH_COMMA:  tok_b.kind = KIND_COMMA;
               CH_PLUS, CH_STAR, CH_PCT: tok_b.kind = KIND_BINOP;
               default: begin
                  tok_b.kind = KIND_ERROR;
                  nxt.mode   = MODE_ERR;
                  nxt.length = '0;
                  nxt.prefix = '0;
               end
            endcase
         end
      end

      // end of stream flushes the pending run or '='
      if (eos) begin
         if (nxt.mode == MODE_IDENT || nxt.mode == MODE_NUM) begin
            vld_c = 1'b1;
            tok_c = '{kind: (nxt.mode == MODE_IDENT) ? word_kind(nxt.length, nxt.prefix)
                                                     : KIND_NUMBER,
                      start: nxt.start, length: nxt.length};
         end else if (nxt.mode == MODE_EQ) begin
            vld_c = 1'b1;
            tok_c = '{kind: KIND_ASSIGN, start: nxt.start, length: 9'd1};
         end
         nxt.mode   = MODE_IDLE;
         nxt.length = '0;
         nxt.prefix = '0;
      end
   end

   // pack the up to two tokens in order
   always_comb begin
      total     = 2'({1'b0, vld_a} + {1'b0, vld_b} + {1'b0, vld_c});
      res.count = (total > 2'd2) ? 2'd2 : total;
      res.tok0  = vld_a ? tok_a : (vld_b ? tok_b : tok_c);
      res.tok1  = (vld_a && vld_b) ? tok_b : tok_c;
   end

endmodule

// ----- rtl/core/small_language_lexer.sv -----
// small language lexer top level: input register, lexing core, result queue
// depends on sll_pkg, sll_if (sll_req_if, sll_rsp_if) and sll_lex
//
//  channel   | dir | payload                                              | transaction
//  ----------+-----+------------------------------------------------------+--------------
//  req_chan  | in  | ch, end_of_stream                                    | one character
//  rsp_chan  | out | token_kind, start_offset, lexeme_length, last_of_run | one token
//
// one character a cycle while the queue has room: a character is held in the input
// register and lexed in the cycle it leaves it; its tokens (none, one or two) go into a
// four-entry result queue; the stage moves on only while the queue holds two entries or
// fewer; the output port drains one token a cycle while rsp_chan.ready is high and sets the
// sustained rate
// synchronous active-high reset clears the lexer state, the stream position and the
// queue; a stalled output fills the queue and then back-pressures req_chan.ready
module small_language_lexer (
   input  logic             clock,
   input  logic             reset,
   sll_req_if.sink          req_chan,
   sll_rsp_if.source        rsp_chan
);
   import sll_pkg::*;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    ch_ff;
   logic          eos_ff;

   // lexer state and stream position
   lex_state_type state_ff, state_in;
   logic [31:0]   pos_ff, pos_in;

   // result queue, entry 0 is the head
   rsp_item_type  q_ff [QUEUE_DEPTH];
   rsp_item_type  q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic [QCNT_W-1:0] cnt_after_pop;

   lex_state_type  lex_nxt;
   lex_result_type lex_res;
   logic           fire;
   logic           pop;
   logic           req_take;

   sll_lex u_lex (
      .ch  (ch_ff),
      .eos (eos_ff),
      .pos (pos_ff),
      .cur (state_ff),
      .nxt (lex_nxt),
      .res (lex_res)
   );

   // the held character is lexed when the queue has room for two tokens
   assign fire     = in_valid_ff && (int'(q_cnt_ff) <= QUEUE_DEPTH - 2);
   assign pop      = (q_cnt_ff != '0) && rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || fire;

   assign rsp_chan.valid         = (q_cnt_ff != '0);
   assign rsp_chan.token_kind    = q_ff[0].tok.kind;
   assign rsp_chan.start_offset  = q_ff[0].tok.start;
   assign rsp_chan.lexeme_length = q_ff[0].tok.length;
   assign rsp_chan.last_of_run   = q_ff[0].last;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      state_in = fire ? lex_nxt : state_ff;
      pos_in   = fire ? (pos_ff + 32'd1) : pos_ff;
   end

   // queue update: shift out the head, then append this cycle's tokens
   always_comb begin
      cnt_after_pop = q_cnt_ff - QCNT_W'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
         if (pop) begin
            q_in[i] = (i < QUEUE_DEPTH - 1) ? q_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i]
                                            : q_ff[i];
         end
         if (fire && lex_res.count != 2'd0 && cnt_after_pop == QCNT_W'(i)) begin
            q_in[i].tok  = lex_res.tok0;
            q_in[i].last = (lex_res.count == 2'd1);
         end
         if (fire && lex_res.count == 2'd2 && cnt_after_pop + QCNT_W'(1) == QCNT_W'(i)) begin
            q_in[i].tok  = lex_res.tok1;
            q_in[i].last = 1'b1;
         end
      end
      q_cnt_in = cnt_after_pop + (fire ? QCNT_W'(lex_res.count) : '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{mode: MODE_IDLE, start: '0, length: '0, prefix: '0};
         pos_ff      <= '0;
         q_cnt_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff  <= req_chan.ch;
         eos_ff <= req_chan.end_of_stream;
      end
      q_ff <= q_in;
   end

endmodule

// ----- sim/testbench.sv -----
// self-checking bench for small_language_lexer: character streams in, tokens checked against a
// cycle-free lexer written here; depends on sll_pkg, sll_if and the small_language_lexer rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sll_pkg::*;

   // windows in clock cycles: a quiet stretch with no idling, and one long output hold-off
   localparam int QUIET_FROM = 700;
   localparam int QUIET_TO   = 1200;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 200;
   localparam int STREAM_MIN = 1150;

   // how the lexer sees one character
   typedef enum {
      CC_ALPHA, CC_DIGIT, CC_SPACE, CC_BANG, CC_EQUALS, CC_SINGLE, CC_PERCENT, CC_OTHER
   } char_class_type;

   typedef struct {
      logic [7:0] ch;
      logic       eos;
   } char_item_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] start;
      logic [8:0]  len;
      logic        last;
   } token_rec_type;

   logic clock = 1'b0;
   logic reset;
   bit   hold_off = 1'b0;
   int   cycle = 0;
   int   chars_total = 0;
   int   chars_accepted = 0;
   int   tokens_seen = 0;
   int   fail_count = 0;

   char_item_type pending_chars[$];
   token_rec_type expected_tokens[$];

   // lexer state as the bench tracks it
   mode_type    lx_mode = MODE_IDLE;
   logic [31:0] run_start = '0;
   logic [8:0]  run_len = '0;
   logic [47:0] run_tail = '0;
   logic [31:0] char_pos = '0;

   // tokens produced by the character being lexed
   token_rec_type step_toks[2];
   int            step_count;

   sll_req_if req_chan ();
   sll_rsp_if rsp_chan ();

   small_language_lexer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle <= cycle + 1;

   // ---------------------------------------------------------------------------------------
   // lexer prediction
   // ---------------------------------------------------------------------------------------

   function automatic char_class_type char_class(input logic [7:0] c);
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER) return CC_ALPHA;
      if (c >= "0" && c <= "9") return CC_DIGIT;
      case (c)
         CH_SPACE, CH_TAB, CH_CR, CH_LF: return CC_SPACE;
         CH_BANG:                        return CC_BANG;
         CH_EQ:                          return CC_EQUALS;
         CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
         CH_SEMI, CH_COMMA, CH_PLUS, CH_STAR: return CC_SINGLE;
         CH_PCT:                         return CC_PERCENT;
         default:                        return CC_OTHER;
      endcase
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      case (c)
         CH_LBRACE:              return KIND_LBRACE;
         CH_RBRACE:              return KIND_RBRACE;
         CH_LPAREN:              return KIND_LPAREN;
         CH_RPAREN:              return KIND_RPAREN;
         CH_SEMI:                return KIND_SEMI;
         CH_COMMA:               return KIND_COMMA;
         CH_PLUS, CH_STAR, CH_PCT: return KIND_BINOP;
         default:                return KIND_ERROR;
      endcase
   endfunction

   // keywords are told apart by length first, then by the last characters of the run
   function automatic kind_type word_class(input logic [8:0] len, input logic [47:0] tail);
      case (len)
         9'd3: if (tail == KW_INT) return KIND_TYPE;
         9'd4: if (tail == KW_VOID) return KIND_TYPE;
         9'd5: if (tail == KW_WHILE) return KIND_WHILE;
         9'd6: if (tail == KW_RETURN) return KIND_RETURN;
         default: ;
      endcase
      return KIND_IDENT;
   endfunction

   function automatic void add_token(input kind_type kind, input logic [31:0] start,
                                     input logic [8:0] len);
      if (step_count < 2) begin
         step_toks[step_count] = '{kind, start, len, 1'b0};
         step_count++;
      end
   endfunction

   // error token at this character, then everything is ignored until end of stream
   function automatic void raise_error(input logic [31:0] pos);
      add_token(KIND_ERROR, pos, 9'd1);
      lx_mode  = MODE_ERR;
      run_len  = '0;
      run_tail = '0;
   endfunction

   function automatic void grow_run(input logic [7:0] c, input logic [31:0] pos);
      if (run_len >= MAX_LEXEME) begin
         raise_error(pos);
      end else begin
         run_len  = run_len + 9'd1;
         run_tail = {run_tail[39:0], c};
      end
   endfunction

   function automatic void open_run(input mode_type mode, input logic [7:0] c,
                                    input logic [31:0] pos);
      lx_mode   = mode;
      run_start = pos;
      run_len   = 9'd1;
      run_tail  = {40'd0, c};
   endfunction

   // works out the tokens of one accepted character and queues them as expectations
   task automatic lex_char(input logic [7:0] c, input logic eos);
      char_class_type cls;
      logic [31:0]    pos;
      bit             consumed;
      cls        = char_class(c);
      pos        = char_pos;
      consumed   = 1'b0;
      step_count = 0;

      case (lx_mode)
         MODE_ERR: consumed = 1'b1;
         MODE_IDENT: begin
            // an identifier swallows anything but whitespace and structure characters
            if (cls inside {CC_ALPHA, CC_DIGIT, CC_PERCENT, CC_OTHER}) begin
               grow_run(c, pos);
               consumed = 1'b1;
            end else begin
               add_token(word_class(run_len, run_tail), run_start, run_len);
               lx_mode = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (cls == CC_DIGIT) begin
               grow_run(c, pos);
               consumed = 1'b1;
            end else begin
               add_token(KIND_NUMBER, run_start, run_len);
               lx_mode = MODE_IDLE;
            end
         end
         MODE_BANG, MODE_EQ: begin
            // the held character decides between a two-character operator and '=' / nothing
            if (cls == CC_EQUALS) begin
               add_token(KIND_BINOP, run_start, 9'd2);
               consumed = 1'b1;
            end else if (lx_mode == MODE_EQ) begin
               add_token(KIND_ASSIGN, run_start, 9'd1);
            end
            lx_mode = MODE_IDLE;
         end
         default: lx_mode = MODE_IDLE;
      endcase

      if (!consumed) begin
         case (cls)
            CC_ALPHA:  open_run(MODE_IDENT, c, pos);
            CC_DIGIT:  open_run(MODE_NUM, c, pos);
            CC_SPACE:  ;
            CC_BANG: begin
               lx_mode   = MODE_BANG;
               run_start = pos;
            end
            CC_EQUALS: begin
               lx_mode   = MODE_EQ;
               run_start = pos;
            end
            CC_SINGLE, CC_PERCENT: add_token(single_kind(c), pos, 9'd1);
            default:   raise_error(pos);
         endcase
      end

      // end of stream flushes whatever is pending; a held '!' just vanishes
      if (eos) begin
         case (lx_mode)
            MODE_IDENT: add_token(word_class(run_len, run_tail), run_start, run_len);
            MODE_NUM:   add_token(KIND_NUMBER, run_start, run_len);
            MODE_EQ:    add_token(KIND_ASSIGN, run_start, 9'd1);
            default: ;
         endcase
         lx_mode  = MODE_IDLE;
         run_len  = '0;
         run_tail = '0;
      end

      char_pos = pos + 32'd1;
      for (int i = 0; i < step_count; i++) begin
         step_toks[i].last = (i == step_count - 1);
         expected_tokens.push_back(step_toks[i]);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------------------

   string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string punct_chars = "{}();,+*%";
   string space_chars = " \t\r\n";
   string kw_words[10] = '{"int", "void", "while", "return", "in", "voids", "whil",
                           "returns", "Int", "_void"};

   task automatic push_char(input logic [7:0] c, input logic eos);
      pending_chars.push_back('{c, eos});
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
   endtask

   task automatic end_stream();
      pending_chars[pending_chars.size() - 1].eos = 1'b1;
   endtask

   // identifier body: mostly letters and digits, now and then a byte that merely extends it
   task automatic push_ident(input int len);
      logic [7:0] c;
      push_char(word_chars[$urandom_range(0, 52)], 1'b0);
      for (int i = 1; i < len; i++) begin
         case ($urandom_range(0, 19))
            0:       c = 8'h00;
            1:       c = CH_PCT;
            2:       c = 8'($urandom_range(128, 255));
            default: c = word_chars[$urandom_range(0, 62)];
         endcase
         push_char(c, 1'b0);
      end
   endtask

   task automatic push_number(input int len);
      for (int i = 0; i < len; i++) push_char(8'($urandom_range("0", "9")), 1'b0);
   endtask

   task automatic push_fragment();
      logic [7:0] c;
      int         roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         push_text(kw_words[$urandom_range(0, 9)]);
      end else if (roll < 35) begin
         push_ident($urandom_range(1, 10));
      end else if (roll < 50) begin
         push_number($urandom_range(1, 8));
      end else if (roll < 75) begin
         push_char(punct_chars[$urandom_range(0, 8)], 1'b0);
      end else if (roll < 85) begin
         case ($urandom_range(0, 2))
            0:       push_text("==");
            1:       push_text("!=");
            default: push_char(CH_EQ, 1'b0);
         endcase
      end else if (roll < 90) begin
         push_char(CH_BANG, 1'b0);
      end else if (roll < 95) begin
         // a character the language does not know: breaks the rest of the stream
         do c = 8'($urandom_range(0, 255)); while (char_class(c) != CC_OTHER);
         push_char(c, 1'b0);
      end else begin
         push_char(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 1)) push_char(space_chars[$urandom_range(0, 3)], 1'b0);
   endtask

   // ---------------------------------------------------------------------------------------
   // idling
   // ---------------------------------------------------------------------------------------

   function automatic bit wants_break();
      if (cycle >= QUIET_FROM && cycle < QUIET_TO) return 1'b0;
      return $urandom_range(0, 99) < 8;
   endfunction

   // ---------------------------------------------------------------------------------------
   // driver: offers characters from the pending queue, predicts on each accepted one
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            lex_char(req_chan.ch, req_chan.end_of_stream);
            chars_accepted++;
         end
         // an offered character stays put until the block takes it
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_chars.size() > 0 && !wants_break()) begin
               req_chan.valid         <= 1'b1;
               req_chan.ch            <= pending_chars[0].ch;
               req_chan.end_of_stream <= pending_chars[0].eos;
               void'(pending_chars.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: every token transaction is checked against the oldest expectation
   // ---------------------------------------------------------------------------------------

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : token_check
      token_rec_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               log_failure($sformatf("token %0d unexpected: kind %0d start %0d len %0d last %0b",
                  tokens_seen, rsp_chan.token_kind, rsp_chan.start_offset,
                  rsp_chan.lexeme_length, rsp_chan.last_of_run));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_chan.token_kind != want.kind || rsp_chan.start_offset != want.start ||
                   rsp_chan.lexeme_length != want.len || rsp_chan.last_of_run != want.last)
                  log_failure({
                     $sformatf("token %0d: expected kind %0d start %0d len %0d last %0b",
                        tokens_seen, want.kind, want.start, want.len, want.last),
                     $sformatf(", got kind %0d start %0d len %0d last %0b",
                        rsp_chan.token_kind, rsp_chan.start_offset, rsp_chan.lexeme_length,
                        rsp_chan.last_of_run)});
            end
         end
         rsp_chan.ready <= !hold_off && !wants_break();
      end
   end

   // long output hold-off: the result queue fills and the input side has to stall
   initial begin : backlog
      while (cycle < HOLD_AT) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // generous ceiling, far above the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("** small_language_lexer: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------------

   initial begin : stimulus
      int stream_no;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.ch            = '0;
      req_chan.end_of_stream = 1'b0;
      rsp_chan.ready         = 1'b0;
      stream_no              = 0;

      // every punctuation token, both two-character operators, '=' on its own, a lone bang,
      // a number cut short by ';', '%' running on inside an identifier, two tokens at once
      push_text("{(x1)=9;a!=b==c,!d+e*f%}");
      end_stream();
      // unknown byte at the top of the range, then a NUL ignored in error and cleared at end
      push_char(8'hFF, 1'b0);
      push_char(8'h00, 1'b1);
      // pending '=' flushed as assignment at end of stream
      push_char(CH_EQ, 1'b1);
      // identifier closed by '!', and the held bang dropped at end of stream
      push_text("a!");
      end_stream();

      while (pending_chars.size() < STREAM_MIN) begin
         stream_no++;
         // the longest identifier that fits, and a number one digit too long
         if (stream_no == 4) begin
            push_ident(MAX_LEXEME);
            push_char(CH_SEMI, 1'b0);
         end else if (stream_no == 9) begin
            push_number(MAX_LEXEME + 1);
         end
         repeat ($urandom_range(3, 30)) push_fragment();
         end_stream();
         if ($urandom_range(0, 9) == 0)
            push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      chars_total = pending_chars.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (chars_accepted < chars_total) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      // keep clocking so that a stray extra token would still be caught
      repeat (16) @(posedge clock);

      if (fail_count == 0)
         $display("** small_language_lexer: PASSED **");
      else
         $display("** small_language_lexer: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sll_pkg.sv
rtl/core/sll_if.sv
rtl/core/sll_lex.sv
rtl/core/small_language_lexer.sv
sim/testbench.sv
